/* rtl/tsw_pkg.sv */
package tsw_pkg;

    // field and store widths
    localparam int SIDE_W   = 9;
    localparam int MAX_SIDE = 256;
    localparam int X_W      = $clog2(MAX_SIDE);
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = FRAC_W + SIDE_W;
    localparam int ADDR_W   = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int TEX_W    = 24;
    localparam int CH_W     = 8;
    localparam int OUT_W    = 16;
    localparam int WB       = 8;
    localparam int WGT_W    = 2 * WB + 1;
    localparam int PW       = WGT_W + CH_W;
    localparam int SH       = 2 * WB - 8;
    localparam int ACC_W    = WGT_W + CH_W + 2;
    localparam int CORNERS  = 4;

    // register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FILTER = 2'd2;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // filter modes
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // white for an empty texture
    localparam logic [OUT_W-1:0] WHITE = 16'hFF00;

    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic              mode;
    } t_cfg;

    typedef struct packed {
        logic              vld;
        logic              smp;
        logic [ADDR_W-1:0] idx;
        logic [TEX_W-1:0]  rgb;
        logic [FRAC_W-1:0] fs;
        logic [FRAC_W-1:0] ft;
    } t_in;

    typedef struct packed {
        logic                            vld;
        logic                            smp;
        logic                            blank;
        logic [ADDR_W-1:0]               idx;
        logic [TEX_W-1:0]                rgb;
        logic [X_W-1:0]                  x0;
        logic [X_W-1:0]                  x1;
        logic [ADDR_W-1:0]               row0;
        logic [ADDR_W-1:0]               row1;
        logic [CORNERS-1:0][WGT_W-1:0]   wt;
    } t_req;

    typedef struct packed {
        logic                            vld;
        logic                            blank;
        logic [CORNERS-1:0][TEX_W-1:0]   tex;
        logic [CORNERS-1:0][WGT_W-1:0]   wt;
    } t_tex;

    // clamp a side register to the largest supported side
    function automatic logic [SIDE_W-1:0] side_sat(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
        return r;
    endfunction

endpackage

/* rtl/tsw_coord.sv */
module tsw_coord (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tsw_pkg::t_in  i_in,
    input  tsw_pkg::t_cfg i_cfg,
    output tsw_pkg::t_req o_req
);

    // stage a: scale fractions by the sides
    logic                           r_a_vld, r_a_smp, r_a_blank, r_a_mode;
    logic [tsw_pkg::SIDE_W-1:0]     r_a_w, r_a_h;
    logic [tsw_pkg::PROD_W-1:0]     r_a_ps, r_a_pt;
    logic [tsw_pkg::ADDR_W-1:0]     r_a_idx;
    logic [tsw_pkg::TEX_W-1:0]      r_a_rgb;
    logic [tsw_pkg::SIDE_W-1:0]     n_w, n_h;

    assign n_w = tsw_pkg::side_sat(i_cfg.w);
    assign n_h = tsw_pkg::side_sat(i_cfg.h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_in.vld;
        end
        if (i_en) begin
            r_a_smp   <= i_in.smp;
            r_a_blank <= (n_w == '0) || (n_h == '0);
            r_a_mode  <= i_cfg.mode;
            r_a_w     <= n_w;
            r_a_h     <= n_h;
            r_a_ps    <= tsw_pkg::PROD_W'(i_in.fs) * tsw_pkg::PROD_W'(n_w);
            r_a_pt    <= tsw_pkg::PROD_W'(i_in.ft) * tsw_pkg::PROD_W'(n_h);
            r_a_idx   <= i_in.idx;
            r_a_rgb   <= i_in.rgb;
        end
    end

    // half texel offset with wrap into [0, size)
    function automatic logic [tsw_pkg::PROD_W-1:0] half_shift(
        input logic [tsw_pkg::PROD_W-1:0] p,
        input logic [tsw_pkg::SIDE_W-1:0] size
    );
        logic signed [tsw_pkg::PROD_W+1:0] d;
        d = $signed({2'b00, p}) - $signed((tsw_pkg::PROD_W+2)'(1 << (tsw_pkg::FRAC_W - 1)));
        if (d < 0) begin
            d = d + $signed({2'b00, size, {tsw_pkg::FRAC_W{1'b0}}});
        end
        return d[tsw_pkg::PROD_W-1:0];
    endfunction

    // stage b: integer texel positions and fractional weights
    logic [tsw_pkg::PROD_W-1:0] n_hs, n_ht;
    logic [tsw_pkg::X_W-1:0]    n_x0, n_y0, n_x1, n_y1;
    logic [tsw_pkg::WB-1:0]     n_u1, n_v1;
    logic [tsw_pkg::X_W:0]      n_xi, n_yi;

    always_comb begin
        n_hs = half_shift(r_a_ps, r_a_w);
        n_ht = half_shift(r_a_pt, r_a_h);
        if (r_a_mode == tsw_pkg::MODE_BILINEAR) begin
            n_x0 = n_hs[tsw_pkg::FRAC_W +: tsw_pkg::X_W];
            n_y0 = n_ht[tsw_pkg::FRAC_W +: tsw_pkg::X_W];
            n_u1 = n_hs[tsw_pkg::FRAC_W-1 -: tsw_pkg::WB];
            n_v1 = n_ht[tsw_pkg::FRAC_W-1 -: tsw_pkg::WB];
        end else begin
            n_x0 = r_a_ps[tsw_pkg::FRAC_W +: tsw_pkg::X_W];
            n_y0 = r_a_pt[tsw_pkg::FRAC_W +: tsw_pkg::X_W];
            n_u1 = '0;
            n_v1 = '0;
        end
        n_xi = {1'b0, n_x0} + 1'b1;
        n_yi = {1'b0, n_y0} + 1'b1;
        n_x1 = ({1'b0, n_xi} == {1'b0, r_a_w}) ? '0 : n_xi[tsw_pkg::X_W-1:0];
        n_y1 = ({1'b0, n_yi} == {1'b0, r_a_h}) ? '0 : n_yi[tsw_pkg::X_W-1:0];
    end

    logic                       r_b_vld, r_b_smp, r_b_blank;
    logic [tsw_pkg::SIDE_W-1:0] r_b_w;
    logic [tsw_pkg::X_W-1:0]    r_b_x0, r_b_x1, r_b_y0, r_b_y1;
    logic [tsw_pkg::WB-1:0]     r_b_u1, r_b_v1;
    logic [tsw_pkg::ADDR_W-1:0] r_b_idx;
    logic [tsw_pkg::TEX_W-1:0]  r_b_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_smp   <= r_a_smp;
            r_b_blank <= r_a_blank;
            r_b_w     <= r_a_w;
            r_b_x0    <= n_x0;
            r_b_x1    <= n_x1;
            r_b_y0    <= n_y0;
            r_b_y1    <= n_y1;
            r_b_u1    <= n_u1;
            r_b_v1    <= n_v1;
            r_b_idx   <= r_a_idx;
            r_b_rgb   <= r_a_rgb;
        end
    end

    // stage c: row offsets and corner weights
    logic [tsw_pkg::WB:0] n_u0, n_v0;
    logic [tsw_pkg::X_W+tsw_pkg::SIDE_W-1:0] n_row0, n_row1;

    assign n_u0   = (tsw_pkg::WB+1)'(1 << tsw_pkg::WB) - {1'b0, r_b_u1};
    assign n_v0   = (tsw_pkg::WB+1)'(1 << tsw_pkg::WB) - {1'b0, r_b_v1};
    assign n_row0 = (tsw_pkg::X_W+tsw_pkg::SIDE_W)'(r_b_y0) * r_b_w;
    assign n_row1 = (tsw_pkg::X_W+tsw_pkg::SIDE_W)'(r_b_y1) * r_b_w;

    tsw_pkg::t_req r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_c.vld <= r_b_vld;
        end
        if (i_en) begin
            r_c.smp   <= r_b_smp;
            r_c.blank <= r_b_blank;
            r_c.idx   <= r_b_idx;
            r_c.rgb   <= r_b_rgb;
            r_c.x0    <= r_b_x0;
            r_c.x1    <= r_b_x1;
            r_c.row0  <= n_row0[tsw_pkg::ADDR_W-1:0];
            r_c.row1  <= n_row1[tsw_pkg::ADDR_W-1:0];
            r_c.wt[0] <= tsw_pkg::WGT_W'(n_u0) * tsw_pkg::WGT_W'(n_v0);
            r_c.wt[1] <= tsw_pkg::WGT_W'(r_b_u1) * tsw_pkg::WGT_W'(n_v0);
            r_c.wt[2] <= tsw_pkg::WGT_W'(r_b_u1) * tsw_pkg::WGT_W'(r_b_v1);
            r_c.wt[3] <= tsw_pkg::WGT_W'(n_u0) * tsw_pkg::WGT_W'(r_b_v1);
        end
    end

    assign o_req = r_c;

endmodule

/* rtl/tsw_store.sv */
module tsw_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tsw_pkg::t_req i_req,
    output tsw_pkg::t_tex o_tex
);

    // corner addresses: a (x0,y0), b (x1,y0), c (x1,y1), d (x0,y1)
    logic [tsw_pkg::CORNERS-1:0][tsw_pkg::ADDR_W-1:0] n_addr;
    logic n_wr;
    logic [tsw_pkg::CORNERS-1:0][tsw_pkg::TEX_W-1:0]  w_rd;
    logic                                             r_vld;
    logic                                             r_blank;
    logic [tsw_pkg::CORNERS-1:0][tsw_pkg::WGT_W-1:0]  r_wt;

    assign n_addr[0] = i_req.row0 + tsw_pkg::ADDR_W'(i_req.x0);
    assign n_addr[1] = i_req.row0 + tsw_pkg::ADDR_W'(i_req.x1);
    assign n_addr[2] = i_req.row1 + tsw_pkg::ADDR_W'(i_req.x1);
    assign n_addr[3] = i_req.row1 + tsw_pkg::ADDR_W'(i_req.x0);
    assign n_wr      = i_req.vld && (i_req.smp == tsw_pkg::KIND_LOAD);

    // one copy of the store per corner, every load writes all copies
    for (genvar g = 0; g < tsw_pkg::CORNERS; g++) begin : g_copy
        logic [tsw_pkg::TEX_W-1:0] r_mem [tsw_pkg::STORE_DEPTH];
        logic [tsw_pkg::TEX_W-1:0] r_q;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_wr) begin
                    r_mem[i_req.idx] <= i_req.rgb;
                end
                r_q <= r_mem[n_addr[g]];
            end
        end
        assign w_rd[g] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_req.vld && (i_req.smp == tsw_pkg::KIND_SAMPLE);
        end
        if (i_en) begin
            r_blank <= i_req.blank;
            r_wt    <= i_req.wt;
        end
    end

    // gather the stage outputs
    always_comb begin
        o_tex.vld   = r_vld;
        o_tex.blank = r_blank;
        o_tex.tex   = w_rd;
        o_tex.wt    = r_wt;
    end

endmodule

/* rtl/tsw_blend.sv */
module tsw_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  tsw_pkg::t_tex              i_tex,
    output logic                       o_vld,
    output logic [3*tsw_pkg::OUT_W-1:0] o_rgb
);

    // stage e: weight times channel for every corner
    logic [tsw_pkg::CORNERS-1:0][2:0][tsw_pkg::PW-1:0] r_p;
    logic r_e_vld, r_e_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_tex.vld;
        end
        if (i_en) begin
            r_e_blank <= i_tex.blank;
            for (int k = 0; k < tsw_pkg::CORNERS; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[k][c] <= tsw_pkg::PW'(i_tex.wt[k]) *
                                 tsw_pkg::PW'(i_tex.tex[k][tsw_pkg::CH_W*(2-c) +: tsw_pkg::CH_W]);
                end
            end
        end
    end

    // stage f: sum, round half up, drop to 8.8
    logic [2:0][tsw_pkg::ACC_W-1:0] n_acc;
    logic [3*tsw_pkg::OUT_W-1:0]    n_rgb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = tsw_pkg::ACC_W'(r_p[0][c]) + tsw_pkg::ACC_W'(r_p[1][c]) +
                       tsw_pkg::ACC_W'(r_p[2][c]) + tsw_pkg::ACC_W'(r_p[3][c]);
            if (tsw_pkg::SH > 0) begin
                n_acc[c] = (n_acc[c] + tsw_pkg::ACC_W'(1 << (tsw_pkg::SH - 1)))
                           >> tsw_pkg::SH;
            end
            n_rgb[c*tsw_pkg::OUT_W +: tsw_pkg::OUT_W] = r_e_blank ? tsw_pkg::WHITE :
                n_acc[c][tsw_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_e_vld;
        end
        if (i_en) begin
            o_rgb <= n_rgb;
        end
    end

endmodule

/* rtl/texture_sampler_wrap_bilinear.sv */
// channel  dir  handshake             payload
// s        in   i_s_tvalid/o_s_tready i_s_tdata (104b), i_s_tuser (kind)
// m        out  o_m_tvalid/i_m_tready o_m_tdata (48b)
// cfg      in   i_cfg_we              i_cfg_idx, i_cfg_data
//
// one item per cycle while the output slot is free or being taken
// six register stages: scale, wrap, row multiply, store read, weight multiply, sum
// the store is held in four copies so all four corners are read in the same cycle
// loads write the store at the read stage, so later samples see them in order
// synchronous reset clears valid bits and config; store contents stay undefined
// a stalled output freezes the whole pipeline; nothing is lost or repeated
module texture_sampler_wrap_bilinear (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // texel_index, red_in, green_in, blue_in, coord_s, coord_t
    input  logic [103:0]                i_s_tdata,
    // kind
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // red_out, green_out, blue_out
    output logic [47:0]                 o_m_tdata,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [tsw_pkg::SIDE_W-1:0]  i_cfg_data
);

    tsw_pkg::t_cfg r_cfg;
    tsw_pkg::t_in  n_in;
    tsw_pkg::t_req w_req;
    tsw_pkg::t_tex w_tex;
    logic          n_en;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsw_pkg::CFG_WIDTH:  r_cfg.w    <= i_cfg_data;
                tsw_pkg::CFG_HEIGHT: r_cfg.h    <= i_cfg_data;
                tsw_pkg::CFG_FILTER: r_cfg.mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output slot is free or being taken
    assign n_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = n_en;

    // unpack the input transfer
    assign n_in.vld = i_s_tvalid;
    assign n_in.smp = i_s_tuser;
    assign n_in.idx = i_s_tdata[15:0];
    assign n_in.rgb = i_s_tdata[39:16] == '0 ? '0 :
                      {i_s_tdata[23:16], i_s_tdata[31:24], i_s_tdata[39:32]};
    assign n_in.fs  = i_s_tdata[55:40];
    assign n_in.ft  = i_s_tdata[87:72];

    tsw_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_in    (n_in),
        .i_cfg   (r_cfg),
        .o_req   (w_req)
    );

    tsw_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_req   (w_req),
        .o_tex   (w_tex)
    );

    tsw_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_tex   (w_tex),
        .o_vld   (o_m_tvalid),
        .o_rgb   (o_m_tdata)
    );

endmodule

/* rtl/tsw_checker.sv */
module tsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // input side follows the output slot
    a_ready_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output slot");

    // a new result only appears after the pipeline advanced
    a_rise_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(o_s_tready))
        else $error("result appeared without pipeline advance");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind texture_sampler_wrap_bilinear tsw_checker u_tsw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* sim/tb_texture_sampler_wrap_bilinear.sv */
`timescale 1ns / 1ps

module tb_texture_sampler_wrap_bilinear;

    typedef struct {
        logic        kind;
        logic [15:0] index;
        logic [23:0] rgb;
        logic [31:0] s;
        logic [31:0] t;
    } t_texel_op;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [103:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [tsw_pkg::SIDE_W-1:0] i_cfg_data;

    texture_sampler_wrap_bilinear DUT (.*);

    // pending ops, expected colors and the shadow texture
    t_texel_op   op_queue[$];
    logic [47:0] color_queue[$];
    logic [23:0] shadow_tex [0:65535];
    bit          loaded     [0:65535];
    logic [8:0]  shadow_w;
    logic [8:0]  shadow_h;
    logic        shadow_mode;
    int          mismatches;
    bit          failed;
    bit          long_hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int side_eff(input logic [8:0] v);
        return (v > 9'd256) ? 256 : int'(v);
    endfunction

    function automatic logic [7:0] chan_of(input logic [23:0] tx, input int c);
        return tx[23 - 8*c -: 8];
    endfunction

    // filtered color of one sample from the shadow texture
    function automatic logic [47:0] filtered_color(input logic [15:0] fs,
                                                   input logic [15:0] ft);
        int w;
        int h;
        longint ps;
        longint pt;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint u1;
        longint v1;
        longint acc;
        logic [23:0] ta;
        logic [23:0] tb;
        logic [23:0] tc;
        logic [23:0] td;
        logic [47:0] r;
        w = side_eff(shadow_w);
        h = side_eff(shadow_h);
        if (w == 0 || h == 0) return {tsw_pkg::WHITE, tsw_pkg::WHITE, tsw_pkg::WHITE};
        if (shadow_mode == tsw_pkg::MODE_NEAREST) begin
            x0 = (longint'(fs) * w) >> 16;
            y0 = (longint'(ft) * h) >> 16;
            ta = shadow_tex[16'((y0 * w + x0) & 16'hFFFF)];
            for (int c = 0; c < 3; c++) r[16*c +: 16] = {chan_of(ta, c), 8'h00};
            return r;
        end
        ps = longint'(fs) * w - 32768;
        if (ps < 0) ps += longint'(w) << 16;
        pt = longint'(ft) * h - 32768;
        if (pt < 0) pt += longint'(h) << 16;
        x0 = ps >> 16;
        y0 = pt >> 16;
        x1 = (x0 + 1) % w;
        y1 = (y0 + 1) % h;
        u1 = (ps & 16'hFFFF) >> 8;
        v1 = (pt & 16'hFFFF) >> 8;
        ta = shadow_tex[16'((y0 * w + x0) & 16'hFFFF)];
        tb = shadow_tex[16'((y0 * w + x1) & 16'hFFFF)];
        tc = shadow_tex[16'((y1 * w + x1) & 16'hFFFF)];
        td = shadow_tex[16'((y1 * w + x0) & 16'hFFFF)];
        for (int c = 0; c < 3; c++) begin
            acc = (256 - u1) * (256 - v1) * chan_of(ta, c) + u1 * (256 - v1) * chan_of(tb, c)
                + u1 * v1 * chan_of(tc, c) + (256 - u1) * v1 * chan_of(td, c);
            acc = (acc + 128) >> 8;
            r[16*c +: 16] = 16'(acc);
        end
        return r;
    endfunction

    // sender: bursts with random gaps, prediction at each accepted transfer
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        t_texel_op op;
        t_texel_op acc_op;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                acc_op.kind  = i_s_tuser;
                acc_op.index = i_s_tdata[15:0];
                acc_op.rgb   = {i_s_tdata[23:16], i_s_tdata[31:24], i_s_tdata[39:32]};
                if (acc_op.kind == tsw_pkg::KIND_LOAD) shadow_tex[acc_op.index] = acc_op.rgb;
                else color_queue.push_back(filtered_color(i_s_tdata[55:40],
                                                          i_s_tdata[87:72]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0 || op_queue.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    op = op_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= op.kind;
                    i_s_tdata  <= {op.t, op.s, op.rgb[7:0], op.rgb[15:8], op.rgb[23:16],
                                   op.index};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    int rx_cycle;
    int hold_left;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (long_hold_req && hold_left == 0) begin
            hold_left  <= 120;
            i_m_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            case ((rx_cycle / 150) % 4)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 1) == 1);
                2: i_m_tready <= rx_cycle[0];
                default: i_m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // result check
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (color_queue.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
            end else begin
                want = color_queue.pop_front();
                for (int c = 0; c < 3; c++) begin
                    if (o_m_tdata[16*c +: 16] !== want[16*c +: 16]) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("channel %0d: expected %h, got %h", c,
                                     want[16*c +: 16], o_m_tdata[16*c +: 16]);
                    end
                end
            end
        end
    end

    // settled values are checked away from the active edge
    task automatic wait_idle();
        while (op_queue.size() != 0 || i_s_tvalid || color_queue.size() != 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_texture(input logic [8:0] w, input logic [8:0] h, input logic m);
        wait_idle();
        write_reg(tsw_pkg::CFG_WIDTH, w);
        write_reg(tsw_pkg::CFG_HEIGHT, h);
        write_reg(tsw_pkg::CFG_FILTER, m);
        shadow_w    = w;
        shadow_h    = h;
        shadow_mode = m;
    endtask

    task automatic push_load(input logic [15:0] idx, input logic [23:0] rgb);
        t_texel_op op;
        op.kind  = tsw_pkg::KIND_LOAD;
        op.index = idx;
        op.rgb   = rgb;
        op.s     = $urandom;
        op.t     = $urandom;
        loaded[idx] = 1'b1;
        op_queue.push_back(op);
    endtask

    task automatic push_sample(input logic [31:0] s, input logic [31:0] t);
        t_texel_op op;
        op.kind  = tsw_pkg::KIND_SAMPLE;
        op.index = $urandom;
        op.rgb   = $urandom;
        op.s     = s;
        op.t     = t;
        op_queue.push_back(op);
    endtask

    // fill every texel of the active area that has not been loaded yet
    task automatic fill_area();
        int n;
        n = side_eff(shadow_w) * side_eff(shadow_h);
        for (int i = 0; i < n; i++)
            if (!loaded[i]) push_load(16'(i), $urandom);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return 32'hFFFF0000 | $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // random traffic over the active area: mostly samples, some loads
    task automatic random_traffic(input int count);
        int n;
        n = side_eff(shadow_w) * side_eff(shadow_h);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                if (n > 0 && $urandom_range(0, 1) == 0)
                    push_load(16'($urandom_range(0, n - 1)), $urandom);
                else
                    push_load(16'($urandom), $urandom);
            end else begin
                push_sample(rand_coord(), rand_coord());
            end
        end
    endtask

    // edge coordinates: zero, extremes, negative integer, last fraction, half
    logic [31:0] edge_coords [6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000,
                                     32'h0000FFFF, 32'h00008000};

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = tsw_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        rx_cycle    = 0;
        hold_left   = 0;
        mismatches  = 0;
        failed      = 1'b0;
        long_hold_req = 1'b0;
        shadow_w    = '0;
        shadow_h    = '0;
        shadow_mode = tsw_pkg::MODE_NEAREST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no texture gives white
        push_sample(32'h12345678, 32'h9ABCDEF0);
        set_texture(9'd4, 9'd0, tsw_pkg::MODE_BILINEAR);
        push_sample(32'h00008000, 32'h0);
        set_texture(9'd0, 9'd3, tsw_pkg::MODE_NEAREST);
        push_sample(32'hFFFFFFFF, 32'h0);

        // edge coordinates on a 4x4 texture in both modes
        set_texture(9'd4, 9'd4, tsw_pkg::MODE_NEAREST);
        push_load(16'hFFFF, 24'hFFFFFF);
        push_load(16'h0000, 24'h000000);
        fill_area();
        for (int i = 0; i < 6; i++) push_sample(edge_coords[i], edge_coords[5 - i]);
        set_texture(9'd4, 9'd4, tsw_pkg::MODE_BILINEAR);
        for (int i = 0; i < 6; i++) push_sample(edge_coords[i], edge_coords[(i + 2) % 6]);

        // largest and oversized sides
        set_texture(9'd256, 9'd1, tsw_pkg::MODE_BILINEAR);
        fill_area();
        random_traffic(40);
        set_texture(9'd511, 9'd2, tsw_pkg::MODE_NEAREST);
        fill_area();
        random_traffic(40);
        set_texture(9'd1, 9'd511, tsw_pkg::MODE_BILINEAR);
        fill_area();
        random_traffic(40);

        // random small textures; one phase under a long output hold-off
        for (int p = 0; p < 8; p++) begin
            set_texture(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
                        logic'($urandom_range(0, 1)));
            fill_area();
            if (p == 2) long_hold_req = 1'b1;
            random_traffic(70);
            if (p == 2) begin
                wait (hold_left != 0);
                long_hold_req = 1'b0;
            end
        end
        set_texture(9'd0, 9'd0, tsw_pkg::MODE_NEAREST);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (!failed && color_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
